// File: src/rsc_pkg.sv
// Package for the RPN stack calculator: word format, action and status codes,
// queue command type, sequencer states, and the fixed-point helper functions.
// No dependencies; every other file of the block imports it.
`default_nettype none
package rsc_pkg;

  localparam int STACK_DEPTH  = 32;
  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_BITS     = 30;
  localparam int ANG_SHIFT    = ANG_BITS - FRAC_BITS;
  localparam int IDX_BITS     = $clog2(STACK_DEPTH);
  localparam int CNT_BITS     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_STEPS    = WORD_BITS + FRAC_BITS;
  localparam int SQRT_STEPS   = (WORD_BITS + FRAC_BITS) / 2;
  localparam int RED_STEPS    = WORD_BITS + ANG_SHIFT;
  localparam int STEP_BITS    = 6;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QP_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QC_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [33:0] TWO_PI_Q = 34'd6746518852;
  localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;
  localparam logic signed [34:0] PI_S      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;
  localparam logic signed [33:0] GAIN_S    = 34'sd652032874;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_ABS   = 4'd5,
    OP_SIN   = 4'd6,
    OP_COS   = 4'd7,
    OP_SQRT  = 4'd8,
    OP_DUP   = 4'd9,
    OP_DROP  = 4'd10,
    OP_CLEAR = 4'd11,
    OP_PRINT = 4'd12,
    OP_NOP   = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_DIV0    = 3'd2,
    ST_SQRTNEG = 3'd3,
    ST_FULL    = 3'd4,
    ST_SAT     = 3'd5
  } st_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH1, S_FETCH2, S_FETCH3, S_EXEC, S_MULF, S_DIV, S_SQRT,
    S_TRED, S_TFIX, S_TFIX2, S_TROT, S_FIN, S_WB, S_OUT, S_PR_RD, S_PR_DAT,
    S_PR_OUT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  need;
    logic [31:0] operand;
  } cmd_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } pk_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic pk_t pack_q(input logic neg, input logic [47:0] mag);
    pk_t r;
    if (neg) begin
      if (mag > 48'h0000_8000_0000) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = ~mag[31:0] + 32'd1;
        r.sat = 1'b0;
      end
    end else if (mag > 48'h0000_7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else begin
      r.val = mag[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [29:0] atan_q(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/rpn_stack_calculator_unit.sv
// Top level of the RPN stack calculator: front end, command queue and back end.
// Depends on rsc_pkg, rsc_front, rsc_queue and rsc_back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   item     | item_valid / item_stall    | action, operand
//   result   | result_valid / result_stall| value, status, from_print, last
//
// An action is fetched, executed, written back and sent; mul adds a multiply
// step, div and sqrt a bit-serial loop, sin and cos angle reduction and CORDIC.
// Print sends one transfer per entry, paced by the single stack read port.
// Reset is synchronous; it empties the stack and the command queue.
// The queue holds two commands, so items are taken while a result is stalled.
`default_nettype none
module rpn_stack_calculator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [3:0]  action,
  input  logic [31:0] operand,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] value,
  output logic [2:0]  status,
  output logic        from_print,
  output logic        last
);
  import rsc_pkg::*;

  cmd_t f_cmd;
  cmd_t b_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  rsc_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .operand    (operand),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (f_cmd)
  );

  rsc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (f_cmd),
    .pop    (q_pop),
    .rd_cmd (b_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  rsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_empty),
    .q_cmd        (b_cmd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .status       (status),
    .from_print   (from_print),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !from_print |-> last)
    else $error("Result of a non-print action is not marked last.");

  a_print_status_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && from_print |-> status == 3'(ST_OK))
    else $error("Print transfer carries a nonzero status.");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !item_stall)
    else $error("Input stalled while the command queue is empty.");
`endif

endmodule
`default_nettype wire

// File: src/rsc_front.sv
// Front end: takes input transfers and classifies each action into a queue
// command with its opcode and the stack depth it needs. Depends on rsc_pkg.
`default_nettype none
module rsc_front (
  input  logic          item_valid,
  output logic          item_stall,
  input  logic [3:0]    action,
  input  logic [31:0]   operand,
  input  logic          q_full,
  output logic          q_push,
  output rsc_pkg::cmd_t q_cmd
);
  import rsc_pkg::*;

  op_t op;

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    if (action > 4'(OP_PRINT)) begin
      op = OP_NOP;
    end else begin
      op = op_t'(action);
    end
    q_cmd.op      = op;
    q_cmd.operand = operand;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: q_cmd.need = 2'd2;
      OP_ABS, OP_SIN, OP_COS, OP_SQRT, OP_DUP, OP_DROP: q_cmd.need = 2'd1;
      default: q_cmd.need = 2'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/rsc_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on rsc_pkg for the command type and depth.
`default_nettype none
module rsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rsc_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output rsc_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import rsc_pkg::*;

  cmd_t               ent [QUEUE_DEPTH];
  logic [QP_BITS-1:0] wr_ptr;
  logic [QP_BITS-1:0] rd_ptr;
  logic [QC_BITS-1:0] fill;

  assign full   = (fill == QC_BITS'(QUEUE_DEPTH));
  assign empty  = (fill == '0);
  assign rd_cmd = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QP_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QP_BITS'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QC_BITS'(1);
        2'b01:   fill <= fill - QC_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/rsc_back.sv
// Back end: stack memory, sequencer, and the arithmetic units (multiplier,
// bit-serial divider and square root, angle reduction and CORDIC).
// Depends on rsc_pkg.
`default_nettype none
module rsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rsc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [31:0]   value,
  output logic [2:0]    status,
  output logic          from_print,
  output logic          last
);
  import rsc_pkg::*;

  state_t state, state_next;

  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [IDX_BITS-1:0]  rd_addr;
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;

  cmd_t                 cmd;
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  cnt_m1;
  logic [CNT_BITS-1:0]  cnt_m2;
  logic [CNT_BITS-1:0]  wb_cnt;
  logic [IDX_BITS-1:0]  wb_addr;
  logic [31:0]          wb_data;
  logic                 wb_we;
  logic [31:0]          a;
  logic [31:0]          b;
  logic [63:0]          prod;
  logic [47:0]          x_sh;
  logic [34:0]          rem;
  logic [32:0]          q;
  logic                 ovf;
  logic                 neg;
  logic                 flip;
  logic [STEP_BITS-1:0] step;
  logic signed [33:0]   xc;
  logic signed [33:0]   yc;
  logic signed [34:0]   zc;
  st_t                  out_st;

  logic                 under;
  logic                 full;
  logic [31:0]          top;
  logic [31:0]          mag_a;
  logic [31:0]          mag_b;
  logic [63:0]          prod_c;
  logic [31:0]          sum;
  logic                 add_ovf;
  logic [31:0]          add_r;
  logic [47:0]          mul_mag;
  pk_t                  mul_pk;
  pk_t                  abs_pk;
  logic [32:0]          div_rsh;
  logic                 div_ge;
  logic [32:0]          q_sh;
  logic [27:0]          s_rsh;
  logic [27:0]          s_t;
  logic                 s_ge;
  logic [33:0]          t_rsh;
  logic                 t_ge;
  logic [33:0]          r2;
  logic signed [34:0]   z0;
  logic signed [33:0]   xs;
  logic signed [33:0]   ys;
  logic signed [34:0]   at;
  logic signed [34:0]   t_res;
  logic signed [34:0]   t_resn;
  logic signed [34:0]   t_rs;
  logic [47:0]          t_mag;
  pk_t                  fin_pk;

  assign cnt_m1 = count - CNT_BITS'(1);
  assign cnt_m2 = count - CNT_BITS'(2);
  assign under  = (count < CNT_BITS'(cmd.need));
  assign full   = (count == CNT_BITS'(STACK_DEPTH));
  assign top    = (count != '0) ? a : 32'd0;
  assign mag_a  = mag32(a);
  assign mag_b  = mag32(b);
  assign prod_c = mag_a * mag_b;
  assign status = out_st;

  always_comb begin
    sum     = (cmd.op == OP_SUB) ? (b - a) : (b + a);
    add_ovf = ((cmd.op == OP_SUB) ? (a[31] != b[31]) : (a[31] == b[31]))
              && (sum[31] != b[31]);
    add_r   = add_ovf ? (b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum;
    mul_mag = (prod[63:48] != '0) ? '1 : prod[63:16];
    mul_pk  = pack_q(neg, mul_mag);
    abs_pk  = pack_q(1'b0, {16'd0, mag_a});
    div_rsh = {rem[31:0], x_sh[47]};
    div_ge  = (div_rsh >= {1'b0, mag_a});
    q_sh    = {q[31:0], div_ge};
    s_rsh   = {rem[25:0], x_sh[47:46]};
    s_t     = {2'b00, q[23:0], 2'b01};
    s_ge    = (s_rsh >= s_t);
    t_rsh   = {rem[32:0], x_sh[47]};
    t_ge    = (t_rsh >= TWO_PI_Q);
    r2      = (neg && (rem[32:0] != '0)) ? (TWO_PI_Q - {1'b0, rem[32:0]})
                                         : {1'b0, rem[32:0]};
    z0      = $signed({1'b0, r2});
    xs      = yc >>> step;
    ys      = xc >>> step;
    at      = $signed({5'd0, atan_q(step[4:0])});
    t_res   = (cmd.op == OP_COS) ? 35'(xc) : 35'(yc);
    t_resn  = flip ? -t_res : t_res;
    t_rs    = t_resn >>> ANG_SHIFT;
    t_mag   = t_rs[34] ? 48'($unsigned(-t_rs)) : 48'($unsigned(t_rs));
    case (cmd.op)
      OP_DIV:  fin_pk = pack_q(neg, ovf ? '1 : {15'd0, q});
      OP_SQRT: fin_pk = pack_q(1'b0, {15'd0, q});
      default: fin_pk = pack_q(t_rs[34], t_mag);
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (q_valid) state_next = S_FETCH1;
      S_FETCH1: state_next = S_FETCH2;
      S_FETCH2: state_next = S_FETCH3;
      S_FETCH3: state_next = S_EXEC;
      S_EXEC: begin
        if (under) begin
          state_next = S_WB;
        end else begin
          case (cmd.op)
            OP_MUL:          state_next = S_MULF;
            OP_DIV:          state_next = (a == '0) ? S_WB : S_DIV;
            OP_SIN, OP_COS:  state_next = S_TRED;
            OP_SQRT:         state_next = a[31] ? S_WB : S_SQRT;
            OP_PRINT:        state_next = (count == '0) ? S_IDLE : S_PR_RD;
            default:         state_next = S_WB;
          endcase
        end
      end
      S_MULF:   state_next = S_WB;
      S_DIV:    if (step == STEP_BITS'(DIV_STEPS - 1)) state_next = S_FIN;
      S_SQRT:   if (step == STEP_BITS'(SQRT_STEPS - 1)) state_next = S_FIN;
      S_TRED:   if (step == STEP_BITS'(RED_STEPS - 1)) state_next = S_TFIX;
      S_TFIX:   state_next = S_TFIX2;
      S_TFIX2:  state_next = S_TROT;
      S_TROT:   if (step == STEP_BITS'(CORDIC_STEPS - 1)) state_next = S_FIN;
      S_FIN:    state_next = S_WB;
      S_WB:     state_next = S_OUT;
      S_OUT:    if (!result_stall) state_next = S_IDLE;
      S_PR_RD:  state_next = S_PR_DAT;
      S_PR_DAT: state_next = S_PR_OUT;
      S_PR_OUT: begin
        if (!result_stall) begin
          state_next = (count == '0) ? S_IDLE : S_PR_RD;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == S_IDLE) && q_valid;
    mem_we = (state == S_WB) && wb_we;
    case (state)
      S_FETCH2: rd_addr = cnt_m2[IDX_BITS-1:0];
      default:  rd_addr = cnt_m1[IDX_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wb_addr] <= wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE:   if (q_valid) cmd <= q_cmd;
        S_FETCH2: a <= rdata;
        S_FETCH3: b <= rdata;
        S_EXEC: begin
          wb_we      <= 1'b0;
          wb_cnt     <= count;
          wb_addr    <= cnt_m1[IDX_BITS-1:0];
          wb_data    <= a;
          value      <= top;
          out_st     <= ST_OK;
          from_print <= 1'b0;
          last       <= 1'b1;
          prod       <= prod_c;
          neg        <= a[31] ^ b[31];
          rem        <= '0;
          q          <= '0;
          ovf        <= 1'b0;
          step       <= '0;
          x_sh       <= {mag_b, 16'd0};
          if (under) begin
            out_st <= ST_UNDER;
          end else begin
            case (cmd.op)
              OP_PUSH, OP_DUP: begin
                if (full) begin
                  out_st <= ST_FULL;
                end else begin
                  wb_we   <= 1'b1;
                  wb_addr <= count[IDX_BITS-1:0];
                  wb_data <= (cmd.op == OP_PUSH) ? cmd.operand : a;
                  wb_cnt  <= count + CNT_BITS'(1);
                  value   <= (cmd.op == OP_PUSH) ? cmd.operand : a;
                end
              end
              OP_ADD, OP_SUB: begin
                wb_we   <= 1'b1;
                wb_addr <= cnt_m2[IDX_BITS-1:0];
                wb_data <= add_r;
                wb_cnt  <= cnt_m1;
                value   <= add_r;
                out_st  <= add_ovf ? ST_SAT : ST_OK;
              end
              OP_DIV: if (a == '0) out_st <= ST_DIV0;
              OP_ABS: begin
                if (a[31]) begin
                  wb_we   <= 1'b1;
                  wb_data <= abs_pk.val;
                  value   <= abs_pk.val;
                  out_st  <= abs_pk.sat ? ST_SAT : ST_OK;
                end
              end
              OP_SIN, OP_COS: begin
                neg  <= a[31];
                x_sh <= {mag_a, 16'd0};
              end
              OP_SQRT: begin
                x_sh <= {a, 16'd0};
                if (a[31]) begin
                  wb_we   <= 1'b1;
                  wb_data <= 32'd0;
                  value   <= 32'd0;
                  out_st  <= ST_SQRTNEG;
                end
              end
              OP_DROP: begin
                wb_cnt <= cnt_m1;
                value  <= (count >= CNT_BITS'(2)) ? b : 32'd0;
              end
              OP_CLEAR: begin
                wb_cnt <= '0;
                value  <= 32'd0;
              end
              default: ;
            endcase
          end
        end
        S_MULF: begin
          wb_we   <= 1'b1;
          wb_addr <= cnt_m2[IDX_BITS-1:0];
          wb_data <= mul_pk.val;
          wb_cnt  <= cnt_m1;
          value   <= mul_pk.val;
          out_st  <= mul_pk.sat ? ST_SAT : ST_OK;
        end
        S_DIV: begin
          rem  <= 35'(div_ge ? (div_rsh - {1'b0, mag_a}) : div_rsh);
          x_sh <= x_sh << 1;
          step <= step + STEP_BITS'(1);
          if (!ovf) begin
            if (q > 33'h0_4000_0000) begin
              ovf <= 1'b1;
            end else begin
              q <= q_sh;
              if (q_sh > 33'h0_8000_0000) ovf <= 1'b1;
            end
          end
        end
        S_SQRT: begin
          rem  <= 35'(s_ge ? (s_rsh - s_t) : s_rsh);
          q    <= {q[31:0], s_ge};
          x_sh <= x_sh << 2;
          step <= step + STEP_BITS'(1);
        end
        S_TRED: begin
          rem  <= 35'(t_ge ? (t_rsh - TWO_PI_Q) : t_rsh);
          x_sh <= x_sh << 1;
          step <= step + STEP_BITS'(1);
        end
        S_TFIX: zc <= (z0 > PI_S) ? (z0 - TWO_PI_S) : z0;
        S_TFIX2: begin
          xc   <= GAIN_S;
          yc   <= '0;
          step <= '0;
          if (zc > HALF_PI_S) begin
            zc   <= zc - PI_S;
            flip <= 1'b1;
          end else if (zc < -HALF_PI_S) begin
            zc   <= zc + PI_S;
            flip <= 1'b1;
          end else begin
            flip <= 1'b0;
          end
        end
        S_TROT: begin
          step <= step + STEP_BITS'(1);
          if (!zc[34]) begin
            xc <= xc - xs;
            yc <= yc + ys;
            zc <= zc - at;
          end else begin
            xc <= xc + xs;
            yc <= yc - ys;
            zc <= zc + at;
          end
        end
        S_FIN: begin
          wb_we   <= 1'b1;
          wb_data <= fin_pk.val;
          value   <= fin_pk.val;
          out_st  <= fin_pk.sat ? ST_SAT : ST_OK;
          if (cmd.op == OP_DIV) begin
            wb_addr <= cnt_m2[IDX_BITS-1:0];
            wb_cnt  <= cnt_m1;
          end
        end
        S_WB: begin
          count        <= wb_cnt;
          result_valid <= 1'b1;
        end
        S_OUT:    if (!result_stall) result_valid <= 1'b0;
        S_PR_DAT: begin
          value        <= rdata;
          out_st       <= ST_OK;
          from_print   <= 1'b1;
          last         <= (count == CNT_BITS'(1));
          count        <= cnt_m1;
          result_valid <= 1'b1;
        end
        S_PR_OUT: if (!result_stall) result_valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
